FILE: hw/rtl/lom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_pkg
// Shared constants and controller/datapath command and status types for the
// leave-one-out median block.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W     = $clog2(MAX_ITEMS);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // controller -> datapath
  typedef struct packed {
    logic  wr_en;      // store the accepted value at wr_addr
    idx_t  wr_addr;
    idx_t  rd_addr;    // sample store read address (data next cycle)
    logic  cand_ld;    // latch read data as rank candidate, clear counters
    logic  cmp_en;     // fold read data into the rank counters
    logic  check_en;   // test candidate rank against the middle positions
    logic  out_ld;     // load result register from read data
    logic  out_final;  // result being loaded closes the run
    cnt_t  n;          // number of stored values
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // result register can take a beat this cycle
  } status_t;

endpackage

FILE: hw/rtl/lom_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_in_if
// Input channel: one set element per beat, last marks the end of the set.
// ----------------------------------------------------------------------------
interface lom_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [lom_pkg::DATA_W-1:0]  value;
  logic                               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: hw/rtl/lom_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_out_if
// Result channel: median with one element removed, final_res on the last beat.
// ----------------------------------------------------------------------------
interface lom_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lom_pkg::DATA_W-1:0]  median_without;
  logic                               final_res;

  modport source (output valid, output median_without, output final_res, input ready);
  modport sink   (input valid, input median_without, input final_res, output ready);
endinterface

FILE: hw/rtl/lom_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_datapath
// Sample store, rank counters, middle order statistic registers and the
// result register.
// ----------------------------------------------------------------------------
module lom_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  lom_pkg::cmd_t    cmd,
  input  lom_pkg::data_t   wr_data,
  output lom_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_ready,
  output lom_pkg::data_t   out_value,
  output logic             out_final
);
  import lom_pkg::*;

  data_t mem [MAX_ITEMS];
  data_t rd_data_r;

  data_t cand_r;
  cnt_t  lt_r, lt_nxt;
  cnt_t  le_r, le_nxt;
  data_t lower_r, upper_r;

  logic  out_valid_r, out_valid_nxt;
  data_t out_value_r;
  logic  out_final_r;

  cnt_t  half;
  cnt_t  pos_lo;
  cnt_t  pos_hi;
  logic  hit_lo, hit_hi;
  data_t res;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    rd_data_r <= mem[cmd.rd_addr];
  end

  // rank of candidate: lt = #values below it, le = #values at or below it
  always_comb begin
    lt_nxt = lt_r;
    le_nxt = le_r;
    if (cmd.cand_ld) begin
      lt_nxt = '0;
      le_nxt = '0;
    end else if (cmd.cmp_en) begin
      lt_nxt = lt_r + cnt_t'(rd_data_r < cand_r);
      le_nxt = le_r + cnt_t'(rd_data_r <= cand_r);
    end
  end

  // a one-element set uses position 0 for both middles
  assign half   = cmd.n >> 1;
  assign pos_hi = half;
  assign pos_lo = (cmd.n >= cnt_t'(2)) ? half - cnt_t'(1) : '0;
  assign hit_lo = (lt_r <= pos_lo) && (pos_lo < le_r);
  assign hit_hi = (lt_r <= pos_hi) && (pos_hi < le_r);

  assign res = (rd_data_r <= lower_r) ? upper_r : lower_r;

  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lt_r <= lt_nxt;
    le_r <= le_nxt;
    if (cmd.cand_ld) begin
      cand_r <= rd_data_r;
    end
    if (cmd.check_en && hit_lo) begin
      lower_r <= cand_r;
    end
    if (cmd.check_en && hit_hi) begin
      upper_r <= cand_r;
    end
    if (cmd.out_ld) begin
      out_value_r <= res;
      out_final_r <= cmd.out_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_final = out_final_r;

endmodule

FILE: hw/rtl/lom_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_ctrl
// Sequencer: load, rank selection of the two middles, then result replay.
// ----------------------------------------------------------------------------
module lom_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  lom_pkg::status_t status,
  output lom_pkg::cmd_t    cmd
);
  import lom_pkg::*;

  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_SEL_RD   = 3'd1;
  localparam logic [2:0] S_SEL_LTCH = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_TAIL     = 3'd4;
  localparam logic [2:0] S_CHECK    = 3'd5;
  localparam logic [2:0] S_EMIT_RD  = 3'd6;
  localparam logic [2:0] S_EMIT_LD  = 3'd7;

  logic [2:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  idx_t       c_r, c_nxt;
  idx_t       j_r, j_nxt;
  idx_t       i_r, i_nxt;
  idx_t       n_m1;
  logic       accept;

  assign n_m1   = idx_t'(count_r - cnt_t'(1));
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    c_nxt     = c_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    in_ready  = 1'b0;
    cmd          = '0;
    cmd.n        = count_r;
    cmd.wr_addr  = idx_t'(count_r);
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (accept) begin
          // beats past capacity are dropped, but last still closes the set
          if (count_r < cnt_t'(MAX_ITEMS)) begin
            cmd.wr_en = 1'b1;
            count_nxt = count_r + cnt_t'(1);
          end
          if (in_last) begin
            c_nxt     = '0;
            state_nxt = S_SEL_RD;
          end
        end
      end
      S_SEL_RD: begin
        cmd.rd_addr = c_r;
        state_nxt   = S_SEL_LTCH;
      end
      S_SEL_LTCH: begin
        cmd.cand_ld = 1'b1;
        j_nxt       = '0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        // read j, compare data of j-1 (read data is registered)
        cmd.rd_addr = j_r;
        cmd.cmp_en  = (j_r != '0);
        if (j_r == n_m1) begin
          state_nxt = S_TAIL;
        end else begin
          j_nxt = j_r + idx_t'(1);
        end
      end
      S_TAIL: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        cmd.check_en = 1'b1;
        if (c_r == n_m1) begin
          i_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          c_nxt     = c_r + idx_t'(1);
          state_nxt = S_SEL_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_addr = i_r;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.rd_addr = i_r;   // hold address so read data stays put on stall
        if (status.out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.out_final = (i_r == n_m1);
          if (i_r == n_m1) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r + idx_t'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      c_r     <= '0;
      j_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      c_r     <= c_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
    end
  end

endmodule

FILE: hw/rtl/leave_one_out_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leave_one_out_median
// For each element of a loaded set, the median of the set without it.
// ----------------------------------------------------------------------------
// channel  dir  fields                       meaning
// in_ch    in   value[31:0] s, last          one set element per beat
// out_ch   out  median_without[31:0] s,      one result per stored element,
//               final_res                    in arrival order
//
// Load accepts one beat per cycle; up to 64 elements are kept.
// Selection ranks every element against the whole set through the single
// store read port once the last beat is in.
// Replay: a store read, then a result load, per beat; out_ch.ready can stall.
// rst_n is synchronous; it empties the set and drops a pending result.
// ----------------------------------------------------------------------------
module leave_one_out_median (
  input  logic      clk,
  input  logic      rst_n,
  lom_in_if.sink    in_ch,
  lom_out_if.source out_ch
);
  import lom_pkg::*;

  cmd_t    cmd;
  status_t status;

  lom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lom_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_data   (in_ch.value),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.median_without),
    .out_final (out_ch.final_res)
  );

endmodule
